/* design/sm3_pkg.sv */
// SM3 hash engine: shared types, constants and round helper functions.
// No dependencies; compile first.
`timescale 1ns / 1ps

package sm3_pkg;

    typedef logic [31:0]      t_word;
    typedef logic [7:0][31:0] t_chain;   // index 0 is V0 / register A

    localparam t_chain SM3_IV = {
        32'hb0fb0e4e, 32'he38dee4d, 32'h163138aa, 32'ha96f30bc,
        32'hda8a0600, 32'h172442d7, 32'h4914b2b9, 32'h7380166f
    };

    localparam t_word SM3_T_LOW   = 32'h79cc4519;
    localparam t_word SM3_T_HIGH  = 32'h7a879d8a;
    localparam t_word SM3_PAD_WORD = {8'h80, 24'h000000};

    localparam int unsigned SM3_ROUNDS      = 64;
    localparam int unsigned SM3_BLOCK_WORDS = 16;
    localparam logic [3:0]  SM3_LEN_SLOT    = 4'd14;   // fill at which length goes in
    localparam logic [2:0]  SM3_FULL_BYTES  = 3'd4;

    // Command from the sequencer to the compression core.
    typedef struct packed {
        logic  push;    // shift one word into the block buffer
        logic  init;    // reload the chaining value with the IV
        t_word word;
    } t_core_cmd;

    // Status of the compression core.
    typedef struct packed {
        logic       busy;   // compression rounds running
        logic [3:0] fill;   // words held in the block buffer
    } t_core_stat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD80,
        ST_ZERO,
        ST_LENLO,
        ST_DRAIN,
        ST_OUT
    } t_state;

    function automatic t_word rotl32(input t_word x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic t_word sm3_p0(input t_word x);
        return x ^ rotl32(x, 5'd9) ^ rotl32(x, 5'd17);
    endfunction

    function automatic t_word sm3_p1(input t_word x);
        return x ^ rotl32(x, 5'd15) ^ rotl32(x, 5'd23);
    endfunction

    // Round constant T_j rotated left by j mod 32; constant per round index.
    function automatic t_word sm3_tj(input logic [5:0] j);
        t_word t;
        t = (j < 6'd16) ? SM3_T_LOW : SM3_T_HIGH;
        return rotl32(t, j[4:0]);
    endfunction

endpackage

/* design/sm3_if.sv */
// SM3 hash engine: valid/ready channel interfaces for message words and digest words.
// Depends on sm3_pkg.
`timescale 1ns / 1ps

interface sm3_word_if;
    logic             valid;
    logic             ready;
    sm3_pkg::t_word   message_word;
    logic [2:0]       byte_count;
    logic             last_word;

    modport source (output valid, message_word, byte_count, last_word, input ready);
    modport sink   (input valid, message_word, byte_count, last_word, output ready);
endinterface

interface sm3_digest_if;
    logic             valid;
    logic             ready;
    sm3_pkg::t_word   digest_word;
    logic             digest_last;

    modport source (output valid, digest_word, digest_last, input ready);
    modport sink   (input valid, digest_word, digest_last, output ready);
endinterface

/* design/sm3_core.sv */
// SM3 compression core: 16-word block buffer / expansion window, working
// registers A..H and one shared round unit stepped 64 times per block.
// Depends on sm3_pkg.
`timescale 1ns / 1ps

module sm3_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sm3_pkg::t_core_cmd  i_cmd,
    output sm3_pkg::t_core_stat o_stat,
    output sm3_pkg::t_chain     o_chain
);
    import sm3_pkg::*;

    logic       r_busy, n_busy;
    logic [5:0] r_round, n_round;
    logic [3:0] r_fill, n_fill;
    t_chain     r_chain, n_chain;
    t_chain     r_regs, n_regs;
    t_word      r_win [SM3_BLOCK_WORDS];

    t_word  a12, ss1, ss2, ff, gg, tt1, tt2, w_new, w_in;
    t_chain round_out;
    logic   win_shift;

    // One round: r_win[0] is W_j, r_win[4] is W_{j+4}.
    always_comb begin
        a12 = rotl32(r_regs[0], 5'd12);
        ss1 = rotl32(a12 + r_regs[4] + sm3_tj(r_round), 5'd7);
        ss2 = ss1 ^ a12;
        if (r_round < 6'd16) begin
            ff = r_regs[0] ^ r_regs[1] ^ r_regs[2];
            gg = r_regs[4] ^ r_regs[5] ^ r_regs[6];
        end else begin
            ff = (r_regs[0] & r_regs[1]) | (r_regs[0] & r_regs[2]) | (r_regs[1] & r_regs[2]);
            gg = (r_regs[4] & r_regs[5]) | (~r_regs[4] & r_regs[6]);
        end
        tt1 = ff + r_regs[3] + ss2 + (r_win[0] ^ r_win[4]);
        tt2 = gg + r_regs[7] + ss1 + r_win[0];
        round_out[0] = tt1;
        round_out[1] = r_regs[0];
        round_out[2] = rotl32(r_regs[1], 5'd9);
        round_out[3] = r_regs[2];
        round_out[4] = sm3_p0(tt2);
        round_out[5] = r_regs[4];
        round_out[6] = rotl32(r_regs[5], 5'd19);
        round_out[7] = r_regs[6];
    end

    // W_{j+16} from the sliding window.
    assign w_new = sm3_p1(r_win[0] ^ r_win[7] ^ rotl32(r_win[13], 5'd15))
                 ^ rotl32(r_win[3], 5'd7) ^ r_win[10];
    assign w_in      = r_busy ? w_new : i_cmd.word;
    assign win_shift = r_busy || i_cmd.push;

    always_comb begin
        n_busy  = r_busy;
        n_round = r_round;
        n_fill  = r_fill;
        n_chain = r_chain;
        n_regs  = r_regs;
        if (i_cmd.init) begin
            n_chain = SM3_IV;
        end
        if (r_busy) begin
            n_regs  = round_out;
            n_round = r_round + 6'd1;
            if (r_round == 6'(SM3_ROUNDS - 1)) begin
                n_busy  = 1'b0;
                n_chain = r_chain ^ round_out;
            end
        end else if (i_cmd.push) begin
            n_fill = r_fill + 4'd1;   // wraps to zero on the sixteenth word
            if (r_fill == 4'(SM3_BLOCK_WORDS - 1)) begin
                n_busy  = 1'b1;
                n_regs  = r_chain;
                n_round = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_round <= '0;
            r_fill  <= '0;
            r_chain <= SM3_IV;
            r_regs  <= '0;
        end else begin
            r_busy  <= n_busy;
            r_round <= n_round;
            r_fill  <= n_fill;
            r_chain <= n_chain;
            r_regs  <= n_regs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (win_shift) begin
            for (int i = 0; i < SM3_BLOCK_WORDS - 1; i++) begin
                r_win[i] <= r_win[i + 1];
            end
            r_win[SM3_BLOCK_WORDS - 1] <= w_in;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.fill = r_fill;
    assign o_chain     = r_chain;

    a_no_push_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_cmd.push)
        else $error("word pushed during compression");

    a_idle_round_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_round == '0))
        else $error("round counter not zero between blocks");

    a_start_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_busy) |-> ($past(i_cmd.push) && ($past(r_fill) == 4'(SM3_BLOCK_WORDS - 1))))
        else $error("compression started without a full block");

    a_fill_empty_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_fill == '0))
        else $error("block buffer fill nonzero during compression");

endmodule

/* design/sm3_hash_engine.sv */
// SM3 hash engine top level: input sequencer with padding and length
// insertion, digest output. Depends on sm3_pkg, sm3_if and sm3_core.
`timescale 1ns / 1ps

// Takes a message as big-endian 32-bit words (byte_count valid bytes on the
// final word, 0 only for an empty message) and returns the 256-bit SM3 digest
// as eight words, V0 first, digest_last on the eighth. Padding and the 64-bit
// length are added internally. Every sixteenth buffered word starts a
// compression that holds ready low while its rounds run, one round per
// cycle on a single round unit. After the final word the engine pushes the
// padding words and the length into the buffer, waits for each remaining
// block (one or two) to be compressed, then offers the digest words one
// per cycle as the sink takes them, and is then ready for a new message with
// the IV restored.
module sm3_hash_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    sm3_word_if.sink            i_msg,
    sm3_digest_if.source        o_dig
);
    import sm3_pkg::*;

    t_state      r_state, n_state;
    logic [63:0] r_bitlen, n_bitlen;
    logic [2:0]  r_out_idx, n_out_idx;

    t_core_cmd   core_cmd;
    t_core_stat  core_stat;
    t_chain      chain;
    logic        in_accept;
    logic [2:0]  count_sat;
    t_word       tail_word;

    sm3_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (core_cmd),
        .o_stat  (core_stat),
        .o_chain (chain)
    );

    assign in_accept = i_msg.valid && i_msg.ready;
    assign count_sat = (i_msg.byte_count > SM3_FULL_BYTES) ? SM3_FULL_BYTES
                                                            : i_msg.byte_count;

    // Final word holding 1..3 bytes: keep them, append the 0x80 marker.
    always_comb begin
        case (count_sat)
            3'd1:    tail_word = {i_msg.message_word[31:24], 8'h80, 16'h0000};
            3'd2:    tail_word = {i_msg.message_word[31:16], 8'h80, 8'h00};
            3'd3:    tail_word = {i_msg.message_word[31:8], 8'h80};
            default: tail_word = SM3_PAD_WORD;
        endcase
    end

    always_comb begin
        n_state       = r_state;
        n_bitlen      = r_bitlen;
        n_out_idx     = r_out_idx;
        core_cmd      = '0;
        i_msg.ready   = 1'b0;
        o_dig.valid   = 1'b0;
        o_dig.digest_word = chain[r_out_idx];
        o_dig.digest_last = (r_out_idx == 3'd7);
        unique case (r_state)
            ST_IDLE: begin
                i_msg.ready = !core_stat.busy;
                if (in_accept) begin
                    core_cmd.push = 1'b1;
                    if (!i_msg.last_word) begin
                        core_cmd.word = i_msg.message_word;
                        n_bitlen      = r_bitlen + 64'd32;
                    end else begin
                        n_bitlen = r_bitlen + {58'd0, count_sat, 3'b000};
                        if (count_sat == SM3_FULL_BYTES) begin
                            core_cmd.word = i_msg.message_word;
                            n_state       = ST_PAD80;
                        end else begin
                            core_cmd.word = tail_word;
                            n_state       = ST_ZERO;
                        end
                    end
                end
            end
            ST_PAD80: begin
                if (!core_stat.busy) begin
                    core_cmd.push = 1'b1;
                    core_cmd.word = SM3_PAD_WORD;
                    n_state       = ST_ZERO;
                end
            end
            ST_ZERO: begin
                if (!core_stat.busy) begin
                    core_cmd.push = 1'b1;
                    if (core_stat.fill == SM3_LEN_SLOT) begin
                        core_cmd.word = r_bitlen[63:32];
                        n_state       = ST_LENLO;
                    end else begin
                        core_cmd.word = '0;
                    end
                end
            end
            ST_LENLO: begin
                if (!core_stat.busy) begin
                    core_cmd.push = 1'b1;
                    core_cmd.word = r_bitlen[31:0];
                    n_state       = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!core_stat.busy) begin
                    n_out_idx = '0;
                    n_state   = ST_OUT;
                end
            end
            ST_OUT: begin
                o_dig.valid = 1'b1;
                if (o_dig.ready) begin
                    n_out_idx = r_out_idx + 3'd1;
                    if (r_out_idx == 3'd7) begin
                        core_cmd.init = 1'b1;
                        n_bitlen      = '0;
                        n_state       = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_bitlen  <= '0;
            r_out_idx <= '0;
        end else begin
            r_state   <= n_state;
            r_bitlen  <= n_bitlen;
            r_out_idx <= n_out_idx;
        end
    end

    a_out_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |-> !core_stat.busy)
        else $error("digest offered while compression runs");

    a_len_at_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_ZERO) && (n_state == ST_LENLO)) |-> (core_stat.fill == SM3_LEN_SLOT))
        else $error("length word placed at wrong buffer slot");

    a_empty_after_msg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_OUT) && o_dig.ready && (r_out_idx == 3'd7)) |=>
            ((r_state == ST_IDLE) && (r_bitlen == '0) && (core_stat.fill == '0)))
        else $error("engine not cleared after digest");

endmodule
